### rtl/sc1kd_pkg.sv
package sc1kd_pkg;

  localparam int ScanW = 8;
  localparam int CharW = 7;
  localparam int CodeW = 4;
  localparam int PrefixDepth = 5;
  localparam int QueueDepthDefault = 4;
  localparam int OutDataW = 16;

  localparam logic [ScanW-1:0] PFX_EXT = 8'hE0;
  localparam logic [ScanW-1:0] PFX_PAUSE = 8'hE1;
  localparam logic [ScanW-1:0] PRT_PRESS_1 = 8'h2A;
  localparam logic [ScanW-1:0] PRT_PRESS_3 = 8'h37;
  localparam logic [ScanW-1:0] PRT_REL_1 = 8'hB7;
  localparam logic [ScanW-1:0] PRT_REL_3 = 8'hAA;
  localparam logic [ScanW-1:0] PAUSE_1 = 8'h1D;
  localparam logic [ScanW-1:0] PAUSE_2 = 8'h45;
  localparam logic [ScanW-1:0] PAUSE_4 = 8'h9D;
  localparam logic [ScanW-1:0] PAUSE_5 = 8'hC5;

  localparam logic [CodeW-1:0] KC_UNKNOWN = 4'd0;
  localparam logic [CodeW-1:0] KC_ESC = 4'd1;
  localparam logic [CodeW-1:0] KC_BKSP = 4'd2;
  localparam logic [CodeW-1:0] KC_TAB = 4'd3;
  localparam logic [CodeW-1:0] KC_RETURN = 4'd4;
  localparam logic [CodeW-1:0] KC_CTRL_L = 4'd5;
  localparam logic [CodeW-1:0] KC_SHIFT_L = 4'd6;
  localparam logic [CodeW-1:0] KC_SHIFT_R = 4'd7;
  localparam logic [CodeW-1:0] KC_PRTSCR = 4'd8;
  localparam logic [CodeW-1:0] KC_BREAK = 4'd9;

  // one queued event; pair marks the pause press/release couple
  typedef struct packed {
    logic [CharW-1:0] printable;
    logic [CodeW-1:0] key_code;
    logic             released;
    logic             pair;
  } ev_t;

  function automatic logic [CharW-1:0] char_lookup(input logic [CharW-1:0] idx);
    logic [CharW-1:0] c;
    c = '0;
    unique case (idx)
      7'h02: c = 7'h31;
      7'h03: c = 7'h32;
      7'h04: c = 7'h33;
      7'h05: c = 7'h34;
      7'h06: c = 7'h35;
      7'h07: c = 7'h36;
      7'h08: c = 7'h37;
      7'h09: c = 7'h38;
      7'h0A: c = 7'h39;
      7'h0B: c = 7'h30;
      7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;
      7'h10: c = 7'h51;
      7'h11: c = 7'h57;
      7'h12: c = 7'h45;
      7'h13: c = 7'h52;
      7'h14: c = 7'h54;
      7'h15: c = 7'h59;
      7'h16: c = 7'h55;
      7'h17: c = 7'h49;
      7'h18: c = 7'h4F;
      7'h19: c = 7'h50;
      7'h1A: c = 7'h5B;
      7'h1B: c = 7'h5D;
      7'h1E: c = 7'h41;
      7'h1F: c = 7'h53;
      7'h20: c = 7'h44;
      7'h21: c = 7'h46;
      7'h22: c = 7'h47;
      7'h23: c = 7'h48;
      7'h24: c = 7'h4A;
      7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;
      7'h27: c = 7'h3B;
      7'h28: c = 7'h27;
      7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;
      7'h2C: c = 7'h5A;
      7'h2D: c = 7'h58;
      7'h2E: c = 7'h43;
      7'h2F: c = 7'h56;
      7'h30: c = 7'h42;
      7'h31: c = 7'h4E;
      7'h32: c = 7'h4D;
      7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;
      7'h35: c = 7'h2F;
      7'h37: c = 7'h2A;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CodeW-1:0] named_key(input logic [CharW-1:0] idx);
    logic [CodeW-1:0] k;
    k = KC_UNKNOWN;
    unique case (idx)
      7'h01: k = KC_ESC;
      7'h0E: k = KC_BKSP;
      7'h0F: k = KC_TAB;
      7'h1C: k = KC_RETURN;
      7'h1D: k = KC_CTRL_L;
      7'h2A: k = KC_SHIFT_L;
      7'h36: k = KC_SHIFT_R;
      default: k = KC_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

### rtl/scancode_set1_key_decoder.sv
// channel  dir  tdata (low bit up)                                tlast
// s_*      in   scan_byte[7:0]                                    -
// m_*      out  printable[6:0] key_code[10:7] released[11], pad   last_of_run
//
// One byte taken per cycle while the event queue has room; prefix bytes
// are held in the front end and give no transfer.
// An event enters the queue when its closing byte is taken and is then
// registered onto m_tdata; a pause sequence gives two transfers, press then release.
// rst is synchronous and clears pending prefixes, the queue and m_tvalid.
// Stalls on m_tready fill the queue; s_tready drops only when it is full.
module scancode_set1_key_decoder
  import sc1kd_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ScanW-1:0]    s_tdata,  // scan_byte[7:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // printable[6:0], key_code[10:7], released[11]
  output logic                m_tlast
);

  logic take;
  logic ev_valid;
  ev_t  ev;
  ev_t  head;
  logic head_valid;
  logic pop;
  logic not_full;

  assign s_tready = not_full;
  assign take = s_tvalid && s_tready;

  sc1kd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .scan_byte (s_tdata),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  sc1kd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take && ev_valid),
    .push_data (ev),
    .not_full  (not_full),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid)
  );

  sc1kd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

### rtl/sc1kd_front.sv
module sc1kd_front
  import sc1kd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [ScanW-1:0] scan_byte,
  output logic             ev_valid,
  output ev_t              ev
);

  localparam int CntW = $clog2(PrefixDepth + 1);
  localparam int IdxW = $clog2(PrefixDepth);

  logic [ScanW-1:0] prefix_bytes [PrefixDepth];
  logic [CntW-1:0]  prefix_count;
  logic [CntW-1:0]  prefix_count_next;
  logic             hold;
  logic [ScanW-1:0] s0;
  logic [ScanW-1:0] s1;
  logic [CharW-1:0] ch;

  assign s0 = (prefix_count == CntW'(0)) ? scan_byte : prefix_bytes[0];
  assign s1 = (prefix_count == CntW'(1)) ? scan_byte : prefix_bytes[1];
  assign ch = char_lookup(s0[CharW-1:0]);

  always_comb begin
    hold = 1'b0;
    prefix_count_next = '0;
    ev_valid = 1'b0;
    ev = '0;
    if (s0 == PFX_EXT) begin
      if (prefix_count == CntW'(0)) begin
        hold = 1'b1;
      end else if (s1 == PRT_PRESS_1 || s1 == PRT_REL_1) begin
        if (prefix_count < CntW'(3)) begin
          hold = 1'b1;
        end else begin
          // full four bytes: match or drop the lot
          ev_valid = (prefix_bytes[2] == PFX_EXT) &&
                     (scan_byte == ((s1 == PRT_REL_1) ? PRT_REL_3 : PRT_PRESS_3));
          ev.key_code = KC_PRTSCR;
          ev.released = (s1 == PRT_REL_1);
        end
      end else begin
        ev_valid = 1'b1;
        ev.key_code = KC_UNKNOWN;
        ev.released = s1[ScanW-1];
      end
    end else if (s0 == PFX_PAUSE) begin
      if (prefix_count < CntW'(PrefixDepth)) begin
        hold = 1'b1;
      end else begin
        ev_valid = (prefix_bytes[1] == PAUSE_1) && (prefix_bytes[2] == PAUSE_2) &&
                   (prefix_bytes[3] == PFX_PAUSE) && (prefix_bytes[4] == PAUSE_4) &&
                   (scan_byte == PAUSE_5);
        ev.key_code = KC_BREAK;
        ev.pair = 1'b1;
      end
    end else begin
      ev_valid = 1'b1;
      ev.printable = ch;
      ev.key_code = (ch == '0) ? named_key(s0[CharW-1:0]) : KC_UNKNOWN;
      ev.released = s0[ScanW-1];
    end
    if (hold) begin
      prefix_count_next = prefix_count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count <= '0;
    end else if (take) begin
      prefix_count <= prefix_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold) begin
      prefix_bytes[prefix_count[IdxW-1:0]] <= scan_byte;
    end
  end

endmodule

### rtl/sc1kd_fifo.sv
module sc1kd_fifo
  import sc1kd_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ev_t  push_data,
  output logic not_full,
  input  logic pop,
  output ev_t  head,
  output logic not_empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ev_t             slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign not_full = (count != CntW'(Depth));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/sc1kd_back.sv
module sc1kd_back
  import sc1kd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ev_t                 head,
  input  logic                head_valid,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  logic             load;
  logic             second;
  logic [CharW-1:0] printable;
  logic [CodeW-1:0] key_code;
  logic             released;

  assign load = !m_tvalid || m_tready;
  // a pause pair stays at the head until its release half is loaded into the output register
  assign pop = load && head_valid && (!head.pair || second);
  assign m_tdata = {{(OutDataW - CharW - CodeW - 1){1'b0}}, released, key_code, printable};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        second <= head.pair && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      printable <= head.printable;
      key_code <= head.key_code;
      released <= head.pair ? second : head.released;
      m_tlast <= !head.pair || second;
    end
  end

endmodule

### tb/scancode_set1_key_decoder_tb.sv
module scancode_set1_key_decoder_tb
  import sc1kd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // scan codes of the control keys that have no character
  localparam logic [CharW-1:0] SC_ESC = 7'h01;
  localparam logic [CharW-1:0] SC_BKSP = 7'h0E;
  localparam logic [CharW-1:0] SC_TAB = 7'h0F;
  localparam logic [CharW-1:0] SC_ENTER = 7'h1C;
  localparam logic [CharW-1:0] SC_LCTRL = 7'h1D;
  localparam logic [CharW-1:0] SC_LSHIFT = 7'h2A;
  localparam logic [CharW-1:0] SC_RSHIFT = 7'h36;
  localparam int CharMapLen = 89;

  typedef struct packed {
    logic [CharW-1:0] printable;
    logic [CodeW-1:0] key_code;
    logic             released;
    logic             last_of_run;
  } key_event_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ScanW-1:0]    s_tdata = '0;  // scan_byte[7:0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;       // printable[6:0], key_code[10:7], released[11], pad
  logic                m_tlast;       // last_of_run

  key_event_t       expected_events[$];
  logic [ScanW-1:0] held_bytes[0:PrefixDepth-1];
  int               held_count = 0;
  logic [7:0]       char_map[0:CharMapLen-1];
  int               bytes_sent = 0;
  int               fail_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  scancode_set1_key_decoder uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // US layout, indices 89 and up have no character
  initial begin
    char_map = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00
    };
  end

  task automatic push_event(input logic [CharW-1:0] ch, input logic [CodeW-1:0] code,
                            input logic rel, input logic last);
    key_event_t ev;
    ev.printable = ch;
    ev.key_code = code;
    ev.released = rel;
    ev.last_of_run = last;
    expected_events.push_back(ev);
  endtask

  // Decoder prediction: updates the held prefix and queues the events of one byte
  task automatic decode_scan_byte(input logic [ScanW-1:0] b);
    logic [ScanW-1:0] seq[0:5];
    int               n;
    int               len;
    logic [CharW-1:0] idx;
    logic [CharW-1:0] ch;
    logic [CodeW-1:0] code;
    logic             hit;
    n = held_count;
    for (int i = 0; i < n; i++) seq[i] = held_bytes[i];
    seq[n] = b;
    len = n + 1;
    if (seq[0] == PFX_EXT) begin
      if (len == 1) begin
        held_bytes[n] = b;
        held_count = len;
      end else if (seq[1] == PRT_PRESS_1 || seq[1] == PRT_REL_1) begin
        if (len < 4) begin
          held_bytes[n] = b;
          held_count = len;
        end else begin
          held_count = 0;
          if (seq[1] == PRT_PRESS_1) hit = seq[2] == PFX_EXT && seq[3] == PRT_PRESS_3;
          else hit = seq[2] == PFX_EXT && seq[3] == PRT_REL_3;
          if (hit) push_event('0, KC_PRTSCR, seq[1] == PRT_REL_1, 1'b1);
        end
      end else begin
        held_count = 0;
        push_event('0, KC_UNKNOWN, seq[1][7], 1'b1);
      end
    end else if (seq[0] == PFX_PAUSE) begin
      if (len < 6) begin
        held_bytes[n] = b;
        held_count = len;
      end else begin
        held_count = 0;
        if (seq[1] == PAUSE_1 && seq[2] == PAUSE_2 && seq[3] == PFX_PAUSE &&
            seq[4] == PAUSE_4 && seq[5] == PAUSE_5) begin
          push_event('0, KC_BREAK, 1'b0, 1'b0);
          push_event('0, KC_BREAK, 1'b1, 1'b1);
        end
      end
    end else begin
      held_count = 0;
      idx = seq[0][6:0];
      ch = (idx < CharMapLen) ? char_map[idx][6:0] : '0;
      code = KC_UNKNOWN;
      if (ch == '0) begin
        case (idx)
          SC_ESC:    code = KC_ESC;
          SC_BKSP:   code = KC_BKSP;
          SC_TAB:    code = KC_TAB;
          SC_ENTER:  code = KC_RETURN;
          SC_LCTRL:  code = KC_CTRL_L;
          SC_LSHIFT: code = KC_SHIFT_L;
          SC_RSHIFT: code = KC_SHIFT_R;
          default:   code = KC_UNKNOWN;
        endcase
      end
      push_event(ch, code, seq[0][7], 1'b1);
    end
  endtask

  // one byte transfer on the slave side; valid stays up into the next call
  task automatic send_scan_byte(input logic [ScanW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    decode_scan_byte(b);
    bytes_sent++;
  endtask

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    fail_count++;
    $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
  endtask

  // result checker and receiver back-pressure
  initial begin
    key_event_t ev;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          $error("event transfer with none expected");
        end else begin
          ev = expected_events.pop_front();
          if (m_tdata[6:0] !== ev.printable)
            report_mismatch("printable", ev.printable, m_tdata[6:0]);
          if (m_tdata[10:7] !== ev.key_code)
            report_mismatch("key_code", ev.key_code, m_tdata[10:7]);
          if (m_tdata[11] !== ev.released)
            report_mismatch("released", ev.released, m_tdata[11]);
          if (m_tlast !== ev.last_of_run)
            report_mismatch("last_of_run", ev.last_of_run, m_tlast);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic test_plain_keys();
    send_scan_byte(8'h00);
    send_scan_byte(8'h01);
    send_scan_byte(8'h1E);
    send_scan_byte(8'h59);  // first index past the table
    send_scan_byte(8'h7F);
    send_scan_byte(8'h80);
    send_scan_byte(8'hFF);
  endtask

  task automatic test_extended_keys();
    send_scan_byte(PFX_EXT);
    send_scan_byte(8'hC8);
    // a second E0 closes the pair as a release
    send_scan_byte(PFX_EXT);
    send_scan_byte(PFX_EXT);
  endtask

  task automatic test_print_screen();
    send_scan_byte(PFX_EXT);
    send_scan_byte(PRT_PRESS_1);
    send_scan_byte(PFX_EXT);
    send_scan_byte(PRT_PRESS_3);
    send_scan_byte(PFX_EXT);
    send_scan_byte(PRT_REL_1);
    send_scan_byte(PFX_EXT);
    send_scan_byte(PRT_REL_3);
  endtask

  task automatic test_pause();
    send_scan_byte(PFX_PAUSE);
    send_scan_byte(PAUSE_1);
    send_scan_byte(PAUSE_2);
    send_scan_byte(PFX_PAUSE);
    send_scan_byte(PAUSE_4);
    send_scan_byte(PAUSE_5);
  endtask

  // mostly framed sequences with random content, some corrupted or cut short
  task automatic test_random_stream(input int count);
    logic [ScanW-1:0] seq[0:5];
    int               stop_at;
    int               kind;
    int               len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        seq[0] = ScanW'($urandom_range(0, 255));
        len = 1;
      end else if (kind < 55) begin
        seq[0] = PFX_EXT;
        seq[1] = ScanW'($urandom_range(0, 255));
        len = 2;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            {seq[0], seq[1], seq[2], seq[3]} = {PFX_EXT, PRT_PRESS_1, PFX_EXT, PRT_PRESS_3};
            len = 4;
          end
          1: begin
            {seq[0], seq[1], seq[2], seq[3]} = {PFX_EXT, PRT_REL_1, PFX_EXT, PRT_REL_3};
            len = 4;
          end
          default: begin
            {seq[0], seq[1], seq[2], seq[3], seq[4], seq[5]} =
                {PFX_PAUSE, PAUSE_1, PAUSE_2, PFX_PAUSE, PAUSE_4, PAUSE_5};
            len = 6;
          end
        endcase
        if (kind >= 92) len = $urandom_range(1, len - 1);
        else if (kind >= 80) seq[$urandom_range(1, len - 1)] = ScanW'($urandom_range(0, 255));
      end
      for (int i = 0; i < len; i++) send_scan_byte(seq[i]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 13;
    recv_idle_pct = 81;
    test_plain_keys();
    test_extended_keys();
    test_print_screen();
    test_pause();
    test_random_stream(600);
    send_idle_pct = 81;
    recv_idle_pct = 13;
    test_random_stream(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(625);
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
rtl/sc1kd_pkg.sv
rtl/sc1kd_front.sv
rtl/sc1kd_fifo.sv
rtl/sc1kd_back.sv
rtl/scancode_set1_key_decoder.sv
tb/scancode_set1_key_decoder_tb.sv
